[src/prg_pkg.sv]
// prg_pkg: shared types, register codes and sizing constants for point_roi_gate
// no dependencies; imported by every module of the block
`default_nettype none

package prg_pkg;

  // frame length limit (index wraps, kept count saturates)
  localparam int unsigned MAX_POINTS = 1048576;
  localparam int unsigned IDX_W      = $clog2(MAX_POINTS);
  localparam int unsigned KEPT_CAP   = (MAX_POINTS < 32'h1FFFFF) ? MAX_POINTS : 32'h1FFFFF;

  // configuration register indexes
  localparam logic [2:0] REG_FILTER_EN = 3'd0;
  localparam logic [2:0] REG_ELEV_EN   = 3'd1;
  localparam logic [2:0] REG_MIN_H     = 3'd2;
  localparam logic [2:0] REG_MAX_H     = 3'd3;
  localparam logic [2:0] REG_XY_MAX    = 3'd4;
  localparam logic [2:0] REG_XY_MIN    = 3'd5;
  localparam logic [2:0] REG_SIN_ELEV  = 3'd6;

  localparam int unsigned CFG_DATA_W = 20;

  typedef struct packed {
    logic signed [19:0] x_mm;
    logic signed [19:0] y_mm;
    logic signed [19:0] z_mm;
    logic               frame_last;
  } in_item_t;

  typedef struct packed {
    logic [19:0] point_index;
    logic        keep;
    logic        result_last;
    logic [20:0] kept_total;
  } out_item_t;

  // settings as seen by the datapath
  typedef struct packed {
    logic               filter_en;
    logic               elev_en;
    logic signed [19:0] min_h;
    logic signed [19:0] max_h;
    logic [37:0]        xy_max_sq;
    logic [37:0]        xy_lo_sq;
    logic [30:0]        sin_sq;
    logic               sin_pos;
  } cfg_t;

  // controller to datapath
  typedef struct packed {
    logic ld_in;
    logic ld_out;
  } dp_cmd_t;

endpackage

`default_nettype wire

[src/prg_cfg.sv]
// prg_cfg: configuration register file and the squared thresholds derived from it
// depends on prg_pkg
`default_nettype none

module prg_cfg
  import prg_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  wr_en,
  input  wire logic [2:0]            wr_index,
  input  wire logic [CFG_DATA_W-1:0] wr_data,
  output cfg_t                       cfg
);

  logic               filter_en_r;
  logic               elev_en_r;
  logic signed [19:0] min_h_r;
  logic signed [19:0] max_h_r;
  logic [18:0]        xy_max_r;
  logic [18:0]        xy_min_r;
  logic signed [15:0] sin_r;
  logic [37:0]        xy_max_sq_r;
  logic [37:0]        xy_lo_sq_r;
  logic [30:0]        sin_sq_r;
  logic signed [31:0] sin_prod;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filter_en_r <= 1'b1;
      elev_en_r   <= 1'b1;
      min_h_r     <= -20'sd1000;
      max_h_r     <= 20'sd2600;
      xy_max_r    <= 19'd17000;
      xy_min_r    <= 19'd0;
      sin_r       <= -16'sd12803;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_FILTER_EN: filter_en_r <= wr_data[0];
        REG_ELEV_EN:   elev_en_r   <= wr_data[0];
        REG_MIN_H:     min_h_r     <= $signed(wr_data[19:0]);
        REG_MAX_H:     max_h_r     <= $signed(wr_data[19:0]);
        REG_XY_MAX:    xy_max_r    <= wr_data[18:0];
        REG_XY_MIN:    xy_min_r    <= wr_data[18:0];
        REG_SIN_ELEV:  sin_r       <= $signed(wr_data[15:0]);
        default: ;
      endcase
    end
  end

  assign sin_prod = 32'(sin_r) * 32'(sin_r);

  // squares follow the registers in the next cycle
  always_ff @(posedge clk) begin
    xy_max_sq_r <= 38'(xy_max_r) * 38'(xy_max_r);
    xy_lo_sq_r  <= 38'(xy_min_r) * 38'(xy_min_r);
    sin_sq_r    <= sin_prod[30:0];
  end

  assign cfg.filter_en = filter_en_r;
  assign cfg.elev_en   = elev_en_r;
  assign cfg.min_h     = min_h_r;
  assign cfg.max_h     = max_h_r;
  assign cfg.xy_max_sq = xy_max_sq_r;
  assign cfg.xy_lo_sq  = xy_lo_sq_r;
  assign cfg.sin_sq    = sin_sq_r;
  assign cfg.sin_pos   = (sin_r > 16'sd0);

endmodule

`default_nettype wire

[src/prg_ctrl.sv]
// prg_ctrl: sequencing state machine and output handshake for point_roi_gate
// depends on prg_pkg
`default_nettype none

module prg_ctrl
  import prg_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  wire logic out_stall,
  output dp_cmd_t   cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SUM  = 2'd1;
  localparam logic [1:0] ST_MUL  = 2'd2;
  localparam logic [1:0] ST_DEC  = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign out_free   = !out_valid_r || !out_stall;
  assign in_stall   = (state_r != ST_IDLE);
  assign out_valid  = out_valid_r;
  assign cmd.ld_in  = (state_r == ST_IDLE) && in_valid;
  assign cmd.ld_out = (state_r == ST_DEC) && out_free;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_SUM;
      ST_SUM:  state_nxt = ST_MUL;
      ST_MUL:  state_nxt = ST_DEC;
      ST_DEC: begin
        if (out_free) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

[src/prg_dp.sv]
// prg_dp: squares, sums, split elevation products, decision, frame counters, result register
// depends on prg_pkg
`default_nettype none

module prg_dp
  import prg_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire in_item_t in_data,
  input  wire cfg_t     cfg,
  input  wire dp_cmd_t  cmd,
  output out_item_t     out_data
);

  // stage 1: squares of the accepted point
  logic signed [39:0] px, py, pz;
  logic [38:0]        xx_r, yy_r, zz_r;
  logic signed [19:0] z_r;
  logic               last_r;

  // stage 2: sums and height window
  logic [39:0] hd2_r, r2_r;
  logic        height_ok_r;

  // stage 3: partial products and distance window
  logic [50:0] plo_r, phi_r;
  logic        win_ok_r, height_ok2_r;

  // stage 4: decision
  logic [70:0] prod, zzs;
  logic        elev_ok, keep;

  logic [IDX_W-1:0]    idx_r, idx_nxt;
  logic [20:0]         kept_r, kept_nxt, kept_inc;
  logic [IDX_W+19:0]   idx_ext;
  out_item_t           out_r;

  assign px = 40'(in_data.x_mm) * 40'(in_data.x_mm);
  assign py = 40'(in_data.y_mm) * 40'(in_data.y_mm);
  assign pz = 40'(in_data.z_mm) * 40'(in_data.z_mm);

  always_ff @(posedge clk) begin
    if (cmd.ld_in) begin
      xx_r   <= px[38:0];
      yy_r   <= py[38:0];
      zz_r   <= pz[38:0];
      z_r    <= in_data.z_mm;
      last_r <= in_data.frame_last;
    end
  end

  // later stages recompute each cycle; their sources hold while an item is in flight
  always_ff @(posedge clk) begin
    hd2_r       <= 40'(xx_r) + 40'(yy_r);
    r2_r        <= 40'(xx_r) + 40'(yy_r) + 40'(zz_r);
    height_ok_r <= (z_r >= cfg.min_h) && (z_r <= cfg.max_h);

    plo_r        <= 51'(cfg.sin_sq) * 51'(r2_r[19:0]);
    phi_r        <= 51'(cfg.sin_sq) * 51'(r2_r[39:20]);
    win_ok_r     <= (hd2_r <= 40'(cfg.xy_max_sq)) && (hd2_r >= 40'(cfg.xy_lo_sq));
    height_ok2_r <= height_ok_r;
  end

  // compare (32768 z)^2 against sin^2 * r^2, sign handled separately
  assign prod = {phi_r, 20'b0} + 71'(plo_r);
  assign zzs  = {2'b0, zz_r, 30'b0};

  always_comb begin
    if (cfg.sin_pos) begin
      elev_ok = !z_r[19] && (z_r != 20'sd0) && (zzs >= prod);
    end else begin
      elev_ok = !z_r[19] || (prod >= zzs);
    end
    keep = !cfg.filter_en ||
           (height_ok2_r && win_ok_r && (!cfg.elev_en || elev_ok));
  end

  assign kept_inc = (keep && (kept_r < 21'(KEPT_CAP))) ? kept_r + 21'd1 : kept_r;

  always_comb begin
    idx_nxt  = idx_r;
    kept_nxt = kept_r;
    if (cmd.ld_out) begin
      if (last_r) begin
        idx_nxt  = '0;
        kept_nxt = '0;
      end else begin
        idx_nxt  = (idx_r == IDX_W'(MAX_POINTS - 1)) ? '0 : idx_r + IDX_W'(1);
        kept_nxt = kept_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r  <= '0;
      kept_r <= '0;
    end else begin
      idx_r  <= idx_nxt;
      kept_r <= kept_nxt;
    end
  end

  assign idx_ext = {20'b0, idx_r};

  always_ff @(posedge clk) begin
    if (cmd.ld_out) begin
      out_r.point_index <= idx_ext[19:0];
      out_r.keep        <= keep;
      out_r.result_last <= last_r;
      out_r.kept_total  <= kept_inc;
    end
  end

  assign out_data = out_r;

endmodule

`default_nettype wire

[src/point_roi_gate.sv]
// point_roi_gate: top level, joins configuration registers, controller and datapath
// depends on prg_pkg, prg_cfg, prg_ctrl, prg_dp
`default_nettype none

// Region-of-interest gate for LiDAR points. Each item is one point; each
// produces exactly one result with its index in the frame, the keep flag, the
// last flag and the running kept count. An accepted point passes through four
// steps, one per cycle while the output is free: squares, sums, split products
// of the elevation test and the final wide compare, which loads the result
// register. Only one point is worked on at a time, so a new point is taken only
// after the compare has loaded its result, and the last step waits while a
// stalled result still sits in the output register. A finished result may wait
// in the output register while the next point is accepted and worked on.
// Configuration is written through the cfg_ port, which is always ready;
// derived squares follow in the cycle after a write.
module point_roi_gate
  import prg_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire in_item_t              in_data,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output out_item_t                  out_data,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [2:0]            cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t    cfg;
  dp_cmd_t cmd;

  assign cfg_ready = 1'b1;

  prg_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_wdata),
    .cfg      (cfg)
  );

  prg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  prg_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cfg      (cfg),
    .cmd      (cmd),
    .out_data (out_data)
  );

endmodule

`default_nettype wire

[src/prg_chk.sv]
// prg_chk: port-level checks for point_roi_gate, attached by bind
// depends on prg_pkg and the point_roi_gate top level
`default_nettype none

module prg_chk
  import prg_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_stall,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input wire out_item_t out_data
);

  // one point in flight: no item taken right after one is accepted
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("item accepted while previous one in flight");

  // a fresh result is raised after its item has passed the squares, sums and products steps
  a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && !in_stall, 4))
    else $error("result without matching item");

  // a kept point never shows a zero kept count
  a_kept_counts: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.keep |-> out_data.kept_total != 21'd0)
    else $error("kept point with zero count");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

endmodule

bind point_roi_gate prg_chk u_prg_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire
